>>> src/assert_macros.svh
// Assertion macros shared by the frame packer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle.
`define SFCP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SFCP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/sfcp_pkg.sv
// Types, constants and CRC-16/MODBUS functions for the scope frame packer.
package sfcp_pkg;

	localparam int unsigned FRAME_BYTES = 10;
	localparam int unsigned CNT_W = $clog2(FRAME_BYTES);
	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_BYTES - 1);
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef struct packed {
		logic [15:0] crc;
		logic [63:0] data;
	} frame_t;

	// Reflected CRC update over one byte, LSB first.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] din);
		logic [15:0] c;
		c = crc_in ^ {8'h00, din};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Update over one 16-bit word, low byte first.
	function automatic logic [15:0] crc_word(input logic [15:0] crc_in, input logic [15:0] w);
		return crc_byte(crc_byte(crc_in, w[7:0]), w[15:8]);
	endfunction

endpackage

>>> src/sfcp_crc_pipe.sv
// Four-stage CRC pipeline: one channel word folded into the CRC per stage.
`include "assert_macros.svh"

module sfcp_crc_pipe (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [15:0]    channel_one,
	input  logic signed [15:0]    channel_two,
	input  logic signed [15:0]    channel_three,
	input  logic signed [15:0]    channel_four,
	input  logic                  ld_ok,
	output logic                  busy,
	output logic                  frame_vld,
	output sfcp_pkg::frame_t      frame
);

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [63:0] data_s1, data_s2, data_s3, data_s4;
	logic [15:0] crc_s1, crc_s2, crc_s3, crc_s4;
	logic        adv;

	// Hold the whole pipe while a finished frame waits for the serializer.
	assign busy = v_s4 && !ld_ok;
	assign adv  = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1 <= {channel_four, channel_three, channel_two, channel_one};
			crc_s1  <= sfcp_pkg::crc_word(sfcp_pkg::CRC_INIT, channel_one);
			data_s2 <= data_s1;
			crc_s2  <= sfcp_pkg::crc_word(crc_s1, data_s1[31:16]);
			data_s3 <= data_s2;
			crc_s3  <= sfcp_pkg::crc_word(crc_s2, data_s2[47:32]);
			data_s4 <= data_s3;
			crc_s4  <= sfcp_pkg::crc_word(crc_s3, data_s3[63:48]);
		end
	end

	assign frame_vld  = v_s4;
	assign frame.crc  = crc_s4;
	assign frame.data = data_s4;

	`SFCP_ASSERT_NEXT(a_stall_hold, busy, v_s4 && $stable(crc_s4) && $stable(data_s4), "stalled frame changed")
	`SFCP_ASSERT_NEXT(a_stall_no_take, busy && start, v_s1 == $past(v_s1), "item taken while busy")

endmodule

>>> src/sfcp_serializer.sv
// Frame register that shifts out ten bytes, one per cycle.
`include "assert_macros.svh"

module sfcp_serializer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  frame_vld,
	input  sfcp_pkg::frame_t      frame,
	output logic                  ld_ok,
	output logic                  strobe,
	output logic [7:0]            frame_byte,
	output logic                  last_byte
);

	logic [8*sfcp_pkg::FRAME_BYTES-1:0] shift_q;
	logic [sfcp_pkg::CNT_W-1:0]         cnt_q;
	logic                               act_q;
	logic                               ld;

	// Take the next frame when idle or on the closing byte of the current one.
	assign ld_ok = !act_q || (cnt_q == sfcp_pkg::LAST_IDX);
	assign ld    = frame_vld && ld_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= '0;
		end else if (ld) begin
			act_q <= 1'b1;
			cnt_q <= '0;
		end else if (act_q) begin
			if (cnt_q == sfcp_pkg::LAST_IDX) begin
				act_q <= 1'b0;
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			shift_q <= frame;
		end else if (act_q) begin
			shift_q <= shift_q >> 8;
		end
	end

	assign strobe     = act_q;
	assign frame_byte = shift_q[7:0];
	assign last_byte  = act_q && (cnt_q == sfcp_pkg::LAST_IDX);

	`SFCP_ASSERT_NEXT(a_cnt_step, act_q && !last_byte, act_q && cnt_q == $past(cnt_q) + 1'b1, "byte count skipped")
	`SFCP_ASSERT(a_idle_cnt, act_q || cnt_q == '0, "count nonzero while idle")

endmodule

>>> src/scope_frame_crc16_packer.sv
// Scope frame packer: four channel words to a ten-byte CRC-16/MODBUS frame.
//
// An item is taken on start while busy is low. Its frame goes through a
// four-stage CRC pipeline (one channel word per stage) into a frame register
// that sends one byte per cycle on strobe: eight data bytes, low byte first,
// then CRC low and CRC high, the last with last_byte set. The first byte
// appears once the frame has left the fourth stage and been loaded into the
// frame register. The frame register sets the sustained rate, and frames go
// back to back; busy rises while a finished frame waits for that register,
// and the pipe then holds up to four items, the waiting one included.
module scope_frame_crc16_packer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] channel_one,
	input  logic signed [15:0] channel_two,
	input  logic signed [15:0] channel_three,
	input  logic signed [15:0] channel_four,
	output logic               strobe,
	output logic [7:0]         frame_byte,
	output logic               last_byte
);

	logic             ld_ok;
	logic             frame_vld;
	sfcp_pkg::frame_t frame;

	sfcp_crc_pipe u_pipe (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.channel_one   (channel_one),
		.channel_two   (channel_two),
		.channel_three (channel_three),
		.channel_four  (channel_four),
		.ld_ok         (ld_ok),
		.busy          (busy),
		.frame_vld     (frame_vld),
		.frame         (frame)
	);

	sfcp_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_vld  (frame_vld),
		.frame      (frame),
		.ld_ok      (ld_ok),
		.strobe     (strobe),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule

>>> tb/scope_frame_crc16_packer_tb.sv
// Testbench for the scope frame packer: random and corner channel sets checked byte by byte.
`timescale 1ns / 100ps

typedef struct packed {
	logic [7:0] value;
	logic       last;
} frame_entry_t;

class frame_tracker;
	frame_entry_t owed[$];
	int unsigned  failures;

	function new();
		failures = 0;
	endfunction

	// Reflected CRC over the payload bit stream, LSB of the first byte first.
	function logic [15:0] modbus_crc(logic [63:0] payload);
		logic [15:0] acc;
		logic        fb;
		acc = 16'hFFFF;
		for (int i = 0; i < 64; i++) begin
			fb = acc[0] ^ payload[i];
			acc = acc >> 1;
			if (fb)
				acc = acc ^ 16'hA001;
		end
		return acc;
	endfunction

	function void note_channels(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] d);
		logic [63:0]  payload;
		logic [15:0]  crc;
		frame_entry_t entry;
		payload = {d, c, b, a};
		crc = modbus_crc(payload);
		for (int k = 0; k < sfcp_pkg::FRAME_BYTES; k++) begin
			if (k < 8)
				entry.value = payload[8*k +: 8];
			else if (k == 8)
				entry.value = crc[7:0];
			else
				entry.value = crc[15:8];
			entry.last = (k == sfcp_pkg::FRAME_BYTES - 1);
			owed.push_back(entry);
		end
	endfunction

	function void check_byte(logic [7:0] got_value, logic got_last);
		frame_entry_t want;
		if (owed.size() == 0) begin
			$display("%0t: unexpected frame byte %02h last %0b", $time, got_value, got_last);
			failures++;
			return;
		end
		want = owed.pop_front();
		if (got_value !== want.value) begin
			$display("%0t: frame_byte expected %02h actual %02h", $time, want.value, got_value);
			failures++;
		end
		if (got_last !== want.last) begin
			$display("%0t: last_byte expected %0b actual %0b", $time, want.last, got_last);
			failures++;
		end
	endfunction

	function int unsigned outstanding();
		return owed.size();
	endfunction
endclass

module scope_frame_crc16_packer_tb;

	localparam int unsigned LIMIT_CYCLES = 200000;
	localparam int unsigned PHASE_ITEMS = 56;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [15:0] channel_one;
	logic signed [15:0] channel_two;
	logic signed [15:0] channel_three;
	logic signed [15:0] channel_four;
	logic               strobe;
	logic [7:0]         frame_byte;
	logic               last_byte;

	frame_tracker tracker;
	int unsigned  cycles = 0;

	scope_frame_crc16_packer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.channel_one  (channel_one),
		.channel_two  (channel_two),
		.channel_three(channel_three),
		.channel_four (channel_four),
		.strobe       (strobe),
		.frame_byte   (frame_byte),
		.last_byte    (last_byte)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && strobe === 1'b1)
			tracker.check_byte(frame_byte, last_byte);
	end

	// Hold start until busy is low at an edge; that edge ends the transfer.
	task automatic send_channels(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] c, input logic [15:0] d);
		channel_one <= a;
		channel_two <= b;
		channel_three <= c;
		channel_four <= d;
		start <= 1'b1;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		tracker.note_channels(a, b, c, d);
	endtask

	// Drop start for a random number of cycles; junk on the channels must be ignored.
	task automatic sender_idle(input int unsigned pct);
		while ($urandom_range(99) < pct) begin
			start <= 1'b0;
			channel_one <= 16'($urandom);
			channel_two <= 16'($urandom);
			channel_three <= 16'($urandom);
			channel_four <= 16'($urandom);
			@(posedge clk);
		end
	endtask

	function automatic logic [15:0] pick_channel();
		case ($urandom_range(15))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h7FFF;
			3: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		tracker = new();
		arst_n <= 1'b0;
		start <= 1'b0;
		channel_one <= '0;
		channel_two <= '0;
		channel_three <= '0;
		channel_four <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners: zero, all ones, signed extremes, byte halves, alternating bits
		send_channels(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_channels(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_channels(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_channels(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_channels(16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001);
		send_channels(16'h00FF, 16'hFF00, 16'h00FF, 16'hFF00);
		send_channels(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
		send_channels(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
		send_channels(16'h0001, 16'h0000, 16'h0000, 16'h0000);
		send_channels(16'h0000, 16'h0000, 16'h0000, 16'h8000);
		send_channels(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
		send_channels(16'hFFFE, 16'hFF80, 16'hFF00, 16'h8001);
		sender_idle(50);
		send_channels(16'h0102, 16'h0304, 16'h0506, 16'h0708);
		sender_idle(50);
		send_channels(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
		send_channels(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
		for (int i = 0; i < 16; i++) begin
			send_channels(16'h1 << i, ~(16'h1 << i), 16'h1 << (15 - i), ~(16'h1 << (15 - i)));
			if (i % 5 == 0)
				sender_idle(70);
		end

		// sender gaps at 10 %, then 58 %, then none so busy pushes back
		for (int p = 0; p < 3; p++) begin
			int unsigned pct;
			pct = (p == 0) ? 10 : (p == 1) ? 58 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_channels(pick_channel(), pick_channel(), pick_channel(), pick_channel());
				sender_idle(pct);
			end
		end
		start <= 1'b0;

		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (tracker.failures == 0 && tracker.outstanding() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
